// File: rtl/core/ntc_pkg.sv
package ntc_pkg;

    // Field widths
    localparam int COEFF_W = 30;
    localparam int INDEX_W = 6;

    localparam int MAX_LEN_DEFAULT = 32;

    // Modulus and Montgomery constants, R = 2^32
    localparam logic [COEFF_W-1:0] PRIME_MOD = 30'd998244353;
    localparam logic [31:0]        MONT_PINV = 32'd998244351;  // -p^-1 mod 2^32

    // Montgomery multiplier latency in cycles
    localparam int MONT_LAT = 4;

    // R^2 mod p, found by doubling 64 times
    function automatic logic [COEFF_W-1:0] calc_r2();
        logic [COEFF_W:0] r;
        r = (COEFF_W+1)'(1);
        for (int b = 0; b < 64; b++) begin
            r = r << 1;
            if (r >= (COEFF_W+1)'(PRIME_MOD)) begin
                r = r - (COEFF_W+1)'(PRIME_MOD);
            end
        end
        return r[COEFF_W-1:0];
    endfunction

    localparam logic [COEFF_W-1:0] MONT_R2 = calc_r2();

    // Side info that travels with each product down the pipeline
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               run_end;
        logic               ovf;
        logic [INDEX_W-1:0] index;
    } tag_t;

endpackage

// File: rtl/core/ntt_modular_convolution_core.sv
// Channel  Dir  Ports                                               Accept
// s_       in   s_coeff s_to_second s_is_final                      s_valid & s_ready
// m_       out  m_product_coeff m_coeff_index m_run_end m_overflowed m_valid & m_ready
//
// Loading accepts one request per cycle outside a run. A final second-sequence request
// starts a run if the first sequence is not empty. The run reads the two RAMs and issues
// one product a[i]*b[k-i] per cycle while the output is not stalled, n*m in all. A
// product passes the RAM read register, two Montgomery multipliers and an accumulator.
// Reset (aresetn low at a clock edge) clears counts, flags and pipeline valids.
// A stalled output freezes the whole product pipeline; s_ready is low during a run.
module ntt_modular_convolution_core #(
    parameter int MAX_LEN = ntc_pkg::MAX_LEN_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ntc_pkg::COEFF_W-1:0] s_coeff,
    input  logic                        s_to_second,
    input  logic                        s_is_final,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ntc_pkg::COEFF_W-1:0] m_product_coeff,
    output logic [ntc_pkg::INDEX_W-1:0] m_coeff_index,
    output logic                        m_run_end,
    output logic                        m_overflowed
);

    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW     = $clog2(MAX_LEN + 1);
    localparam int KW     = $clog2(2 * MAX_LEN);
    localparam int XW     = KW + 1;
    localparam int STAGES = 2 * ntc_pkg::MONT_LAT + 1;

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       first_count_reg;
    logic [CW-1:0]       second_count_reg;
    logic                overflow_reg;
    logic [KW-1:0]       k_reg;
    logic [CW-1:0]       i_reg;
    ntc_pkg::tag_t       tag_reg [STAGES];
    logic [ntc_pkg::COEFF_W-1:0] acc_reg;
    logic                        m_valid_reg;
    logic [ntc_pkg::COEFF_W-1:0] m_coeff_reg;
    logic [ntc_pkg::INDEX_W-1:0] m_index_reg;
    logic                        m_run_end_reg;
    logic                        m_ovf_reg;

    logic                        adv;
    logic                        load_acc;
    logic [ntc_pkg::COEFF_W-1:0] coeff_red;
    logic                        first_room;
    logic                        second_room;
    logic [CW-1:0]               second_count_next;
    logic                        wr_first;
    logic                        wr_second;
    logic [XW-1:0]               last_k;
    logic [XW-1:0]               k_x;
    logic [XW-1:0]               n_x;
    logic [XW-1:0]               m_x;
    logic [CW-1:0]               i_hi;
    logic [CW-1:0]               i_lo_next;
    logic [XW-1:0]               j_x;
    logic                        issue;
    logic                        k_done;
    logic                        run_last;
    ntc_pkg::tag_t               tag_in;
    logic [ntc_pkg::COEFF_W-1:0] a_data;
    logic [ntc_pkg::COEFF_W-1:0] b_data;
    logic [ntc_pkg::COEFF_W-1:0] mont1_r;
    logic [ntc_pkg::COEFF_W-1:0] prod_r;
    logic [ntc_pkg::COEFF_W:0]   acc_sum;
    logic [ntc_pkg::COEFF_W-1:0] acc_red;

    // Pipeline moves when the output register is free or being drained
    assign adv      = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_LOAD);
    assign load_acc = s_valid && s_ready;

    // Load path
    assign coeff_red   = (s_coeff >= ntc_pkg::PRIME_MOD) ? s_coeff - ntc_pkg::PRIME_MOD
                                                        : s_coeff;
    assign first_room  = (first_count_reg < CW'(MAX_LEN));
    assign second_room = (second_count_reg < CW'(MAX_LEN));
    assign wr_first    = load_acc && !s_to_second && first_room;
    assign wr_second   = load_acc && s_to_second && second_room;
    assign second_count_next = second_room ? second_count_reg + 1'b1 : second_count_reg;

    // Issue indices: i runs from max(0, k-m+1) to min(k, n-1)
    assign n_x     = XW'(first_count_reg);
    assign m_x     = XW'(second_count_reg);
    assign k_x     = XW'(k_reg);
    assign last_k  = n_x + m_x - XW'(2);
    assign i_hi    = (k_x < n_x) ? CW'(k_x) : CW'(n_x - XW'(1));
    assign i_lo_next = (k_x + XW'(1) >= m_x) ? CW'(k_x + XW'(2) - m_x) : '0;
    assign j_x     = k_x - XW'(i_reg);
    assign issue   = (state_reg == ST_RUN) && adv;
    assign k_done  = (i_reg == i_hi);
    assign run_last = k_done && (k_x == last_k);

    always_comb begin
        tag_in         = '0;
        tag_in.valid   = issue;
        tag_in.first   = (k_x < m_x) ? (i_reg == '0)
                                     : (XW'(i_reg) == k_x + XW'(1) - m_x);
        tag_in.last    = k_done;
        tag_in.run_end = run_last;
        tag_in.ovf     = overflow_reg;
        tag_in.index   = ntc_pkg::INDEX_W'(k_reg);
    end

    ntc_ram #(.WIDTH(ntc_pkg::COEFF_W), .DEPTH(MAX_LEN)) u_first_ram (
        .aclk    (aclk),
        .wr_en   (wr_first),
        .wr_addr (first_count_reg[AW-1:0]),
        .wr_data (coeff_red),
        .rd_en   (adv),
        .rd_addr (i_reg[AW-1:0]),
        .rd_data (a_data)
    );

    ntc_ram #(.WIDTH(ntc_pkg::COEFF_W), .DEPTH(MAX_LEN)) u_second_ram (
        .aclk    (aclk),
        .wr_en   (wr_second),
        .wr_addr (second_count_reg[AW-1:0]),
        .wr_data (coeff_red),
        .rd_en   (adv),
        .rd_addr (j_x[AW-1:0]),
        .rd_data (b_data)
    );

    // a*b*R^-1, then times R^2 to leave a*b mod p
    ntc_mont u_mont_ab (
        .aclk (aclk),
        .en   (adv),
        .a    (a_data),
        .b    (b_data),
        .r    (mont1_r)
    );

    ntc_mont u_mont_fix (
        .aclk (aclk),
        .en   (adv),
        .a    (mont1_r),
        .b    (ntc_pkg::MONT_R2),
        .r    (prod_r)
    );

    // Accumulate products of one index
    assign acc_sum = (tag_reg[STAGES-1].first ? '0 : (ntc_pkg::COEFF_W+1)'(acc_reg))
                   + (ntc_pkg::COEFF_W+1)'(prod_r);
    assign acc_red = (acc_sum >= (ntc_pkg::COEFF_W+1)'(ntc_pkg::PRIME_MOD))
                   ? ntc_pkg::COEFF_W'(acc_sum - (ntc_pkg::COEFF_W+1)'(ntc_pkg::PRIME_MOD))
                   : ntc_pkg::COEFF_W'(acc_sum);

    // Control: load, run sequencing, tag pipeline, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_LOAD;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            k_reg            <= '0;
            i_reg            <= '0;
            m_valid_reg      <= 1'b0;
            for (int s = 0; s < STAGES; s++) begin
                tag_reg[s].valid <= 1'b0;
            end
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (load_acc) begin
                        if (!s_to_second) begin
                            if (first_room) begin
                                first_count_reg <= first_count_reg + 1'b1;
                            end else begin
                                overflow_reg <= 1'b1;
                            end
                        end else if (!s_is_final) begin
                            second_count_reg <= second_count_next;
                            if (!second_room) begin
                                overflow_reg <= 1'b1;
                            end
                        end else if (first_count_reg != '0) begin
                            // final second request: start the run
                            second_count_reg <= second_count_next;
                            if (!second_room) begin
                                overflow_reg <= 1'b1;
                            end
                            state_reg <= ST_RUN;
                            k_reg     <= '0;
                            i_reg     <= '0;
                        end else begin
                            // nothing to multiply, drop the run
                            first_count_reg  <= '0;
                            second_count_reg <= '0;
                            overflow_reg     <= 1'b0;
                        end
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (run_last) begin
                            state_reg        <= ST_LOAD;
                            first_count_reg  <= '0;
                            second_count_reg <= '0;
                            overflow_reg     <= 1'b0;
                        end else if (k_done) begin
                            k_reg <= k_reg + 1'b1;
                            i_reg <= i_lo_next;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase

            if (adv) begin
                tag_reg[0] <= tag_in;
                for (int s = 1; s < STAGES; s++) begin
                    tag_reg[s] <= tag_reg[s-1];
                end
                m_valid_reg <= tag_reg[STAGES-1].valid && tag_reg[STAGES-1].last;
            end
        end
    end

    // Accumulator and output payload
    always_ff @(posedge aclk) begin
        if (adv && tag_reg[STAGES-1].valid) begin
            acc_reg <= acc_red;
            if (tag_reg[STAGES-1].last) begin
                m_coeff_reg   <= acc_red;
                m_index_reg   <= tag_reg[STAGES-1].index;
                m_run_end_reg <= tag_reg[STAGES-1].run_end;
                m_ovf_reg     <= tag_reg[STAGES-1].ovf;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_product_coeff = m_coeff_reg;
    assign m_coeff_index   = m_index_reg;
    assign m_run_end       = m_run_end_reg;
    assign m_overflowed    = m_ovf_reg;

    // Results are fully reduced
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_product_coeff < ntc_pkg::PRIME_MOD))
        else $error("result not reduced");

    // Issued first-sequence index stays inside the loaded data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (i_reg < first_count_reg))
        else $error("first index out of range");

    // Issued second-sequence index stays inside the loaded data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (j_x < m_x))
        else $error("second index out of range");

endmodule

// File: rtl/core/ntc_ram.sv
module ntc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ntc_mont.sv
// Pipelined Montgomery product: r = a * b * 2^-32 mod p.
module ntc_mont (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [ntc_pkg::COEFF_W-1:0] a,
    input  logic [ntc_pkg::COEFF_W-1:0] b,
    output logic [ntc_pkg::COEFF_W-1:0] r
);

    logic [2*ntc_pkg::COEFF_W-1:0] prod_reg;
    logic [2*ntc_pkg::COEFF_W-1:0] prod_d_reg;
    logic [31:0]                   m_reg;
    logic [30:0]                   t_reg;
    logic [ntc_pkg::COEFF_W-1:0]   r_reg;

    logic [31:0] m_next;
    logic [62:0] sum_next;
    logic [30:0] t_next;

    // m = (x mod 2^32) * (-p^-1) mod 2^32
    assign m_next   = 32'(prod_reg[31:0] * ntc_pkg::MONT_PINV);
    // t = (x + m*p) / 2^32, below 2p
    assign sum_next = 63'(prod_d_reg) + 63'(m_reg) * 63'(ntc_pkg::PRIME_MOD);
    assign t_next   = sum_next[62:32];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= (2*ntc_pkg::COEFF_W)'(a) * (2*ntc_pkg::COEFF_W)'(b);
            prod_d_reg <= prod_reg;
            m_reg      <= m_next;
            t_reg      <= t_next;
            r_reg      <= (t_reg >= 31'(ntc_pkg::PRIME_MOD))
                        ? ntc_pkg::COEFF_W'(t_reg - 31'(ntc_pkg::PRIME_MOD))
                        : ntc_pkg::COEFF_W'(t_reg);
        end
    end

    assign r = r_reg;

endmodule

// File: tb/sv/ntt_modular_convolution_core_tb.sv
`timescale 1ns / 100ps

module ntt_modular_convolution_core_tb;

    localparam int COEFF_W = ntc_pkg::COEFF_W;
    localparam int INDEX_W = ntc_pkg::INDEX_W;
    localparam int LEN = ntc_pkg::MAX_LEN_DEFAULT;
    localparam longint unsigned MODULUS = 998244353;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic [INDEX_W-1:0] index;
        logic               run_end;
        logic               ovf;
    } product_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [COEFF_W-1:0] s_coeff;
    logic               s_to_second;
    logic               s_is_final;
    logic               m_valid;
    logic               m_ready;
    logic [COEFF_W-1:0] m_product_coeff;
    logic [INDEX_W-1:0] m_coeff_index;
    logic               m_run_end;
    logic               m_overflowed;

    // predictor state
    logic [COEFF_W-1:0] poly_a [LEN];
    logic [COEFF_W-1:0] poly_b [LEN];
    int                 len_a;
    int                 len_b;
    logic               dropped;
    product_t           product_q[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  mismatches;
    int  cycles;

    ntt_modular_convolution_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_coeff(s_coeff),
        .s_to_second(s_to_second), .s_is_final(s_is_final),
        .m_valid(m_valid), .m_ready(m_ready), .m_product_coeff(m_product_coeff),
        .m_coeff_index(m_coeff_index), .m_run_end(m_run_end),
        .m_overflowed(m_overflowed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // load one request into the predictor, expand the product on a final second request
    task automatic predict_request(input logic [COEFF_W-1:0] raw, input logic sec,
                                   input logic fin);
        logic [COEFF_W-1:0] c;
        longint unsigned    acc;
        int                 total;
        product_t           p;
        c = (raw >= COEFF_W'(MODULUS)) ? raw - COEFF_W'(MODULUS) : raw;
        if (!sec) begin
            if (len_a < LEN) begin
                poly_a[len_a] = c;
                len_a++;
            end else begin
                dropped = 1'b1;
            end
        end else begin
            if (len_b < LEN) begin
                poly_b[len_b] = c;
                len_b++;
            end else begin
                dropped = 1'b1;
            end
            if (fin) begin
                if (len_a > 0 && len_b > 0) begin
                    total = len_a + len_b - 1;
                    for (int k = 0; k < total; k++) begin
                        acc = 0;
                        for (int i = 0; i < len_a; i++) begin
                            if (k - i >= 0 && k - i < len_b) begin
                                acc = (acc + (longint'(poly_a[i]) * longint'(poly_b[k-i]))
                                       % MODULUS) % MODULUS;
                            end
                        end
                        p.coeff   = COEFF_W'(acc);
                        p.index   = INDEX_W'(k);
                        p.run_end = (k == total - 1);
                        p.ovf     = dropped;
                        product_q.push_back(p);
                    end
                end
                len_a   = 0;
                len_b   = 0;
                dropped = 1'b0;
            end
        end
    endtask

    // offer one request, with a random gap first
    task automatic send_request(input logic [COEFF_W-1:0] c, input logic sec,
                                input logic fin);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(4)) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_coeff     = c;
        s_to_second = sec;
        s_is_final  = fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(c, sec, fin);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (product_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(7))
            0: return '0;
            1: return COEFF_W'(MODULUS - 1);
            2: return '1;
            3: return COEFF_W'(MODULUS + $urandom_range(1000));
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // one run of random contents, first and second requests interleaved
    task automatic send_run(input int na, input int nb);
        logic sec;
        while (na + nb > 1) begin
            sec = (na == 0) || (nb > 1 && $urandom_range(3) == 0);
            if (sec) begin
                send_request(pick_coeff(), 1'b1, 1'b0);
                nb--;
            end else begin
                send_request(pick_coeff(), 1'b0, $urandom_range(7) == 0);
                na--;
            end
        end
        send_request(pick_coeff(), 1'b1, 1'b1);
    endtask

    task automatic test_extremes();
        send_request(COEFF_W'(MODULUS - 1), 1'b0, 1'b0);
        send_request('1, 1'b0, 1'b0);
        send_request('0, 1'b0, 1'b1);
        send_request(COEFF_W'(MODULUS), 1'b1, 1'b0);
        send_request(COEFF_W'(MODULUS - 1), 1'b1, 1'b1);
        // single by single
        send_request(30'h2AAAAAAA, 1'b0, 1'b0);
        send_request(30'h15555555, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_empty_and_order();
        // empty first sequence
        send_request(30'd7, 1'b1, 1'b0);
        send_request(30'd9, 1'b1, 1'b1);
        // first request after a second request
        send_request(30'd3, 1'b1, 1'b0);
        send_request(30'd5, 1'b0, 1'b0);
        send_request(30'd11, 1'b1, 1'b1);
        wait_drained();
        repeat (40) @(posedge aclk);
    endtask

    task automatic test_overflow();
        send_run(LEN + 1, LEN + 1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                recv_hold = 1'b0;
            end
        join_none
        send_run(6, 5);
        send_run(3, 4);
        send_run(2, 2);
        wait_drained();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int nreq);
        int sent;
        int na;
        int nb;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < nreq) begin
            if ($urandom_range(15) == 0) begin
                na = $urandom_range(LEN - 4, LEN + 1);
                nb = $urandom_range(1, 3);
            end else begin
                na = $urandom_range(0, 6);
                nb = $urandom_range(1, 6);
            end
            send_run(na, nb);
            sent += na + nb;
        end
        wait_drained();
        repeat (40) @(posedge aclk);
    endtask

    // receiver readiness
    always @(negedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // result check
    always @(posedge aclk) begin
        product_t want;
        if (aresetn && m_valid && m_ready) begin
            if (product_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result coeff=%0d index=%0d",
                             m_product_coeff, m_coeff_index);
            end else begin
                want = product_q.pop_front();
                if (m_product_coeff !== want.coeff || m_coeff_index !== want.index ||
                    m_run_end !== want.run_end || m_overflowed !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                                 want.coeff, want.index, want.run_end, want.ovf,
                                 m_product_coeff, m_coeff_index, m_run_end, m_overflowed);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[ntt_modular_convolution_core] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_coeff       = '0;
        s_to_second   = 1'b0;
        s_is_final    = 1'b0;
        m_ready       = 1'b0;
        recv_hold     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatches    = 0;
        cycles        = 0;
        len_a         = 0;
        len_b         = 0;
        dropped       = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_extremes();
        test_empty_and_order();
        test_overflow();
        test_backpressure();
        test_random(29, 68, 16);
        test_random(68, 29, 16);
        test_random(0, 0, 16);

        repeat (50) @(posedge aclk);
        if (mismatches == 0 && product_q.size() == 0)
            $display("[ntt_modular_convolution_core] OK");
        else
            $display("[ntt_modular_convolution_core] ERROR");
        $finish;
    end

endmodule
